// ===== sv/mascd_pkg.sv =====
package mascd_pkg;

	localparam int NUM_CHANNELS_DEF = 32;

	localparam int CH_W       = 5;
	localparam int SAMPLE_W   = 10;
	localparam int SEL_W      = 2;
	localparam int MUX_W      = 4;
	localparam int SKIP_W     = 6;
	localparam int MASK_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_W      = 21;
	localparam int OUT_DATA_W = 24;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP      = 2'd2;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd4;
	localparam logic [SKIP_W-1:0]   SKIP_RST      = 6'd32;

	// item kinds on s_tuser
	localparam logic MODE_CONV = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [SEL_W-1:0] SEL_AFTER_RESET = 2'd1;

	typedef struct packed {
		logic             conv;
		logic [CH_W-1:0]  ch;
		logic [SEL_W-1:0] adc_select;
		logic             mux_reset;
		logic             mux_a_clk;
		logic             mux_b_clk;
	} scan_res_t;

endpackage

// ===== sv/mascd_store.sv =====
module mascd_store #(
	parameter int DEPTH  = mascd_pkg::NUM_CHANNELS_DEF,
	parameter int DATA_W = mascd_pkg::SAMPLE_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] mem_q;
	logic [DATA_W-1:0] byp_data_q;
	logic [DEPTH-1:0]  vld_q;
	logic              byp_q;
	logic              hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q      <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			byp_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (rd_en) begin
				byp_q <= wr_en && (wr_addr == rd_addr);
				hit_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = byp_q ? byp_data_q : (hit_q ? mem_q : '0);

endmodule

// ===== sv/mascd_scan.sv =====
module mascd_scan #(
	parameter int NUM_CHANNELS = mascd_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic                                mode,
	input  logic [mascd_pkg::SKIP_W-1:0]        skip_from_channel,
	output logic [$clog2(NUM_CHANNELS)-1:0]     rd_addr,
	output mascd_pkg::scan_res_t                res
);

	localparam int IDX_W  = $clog2(NUM_CHANNELS);
	localparam int SKIP_W = mascd_pkg::SKIP_W;
	localparam int MUX_W  = mascd_pkg::MUX_W;

	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [MUX_W-1:0]  a_cur_q, a_cur_d, a_tgt_q, a_tgt_d;
	logic [MUX_W-1:0]  b_cur_q, b_cur_d, b_tgt_q, b_tgt_d;
	logic [SKIP_W-1:0] ch_w, nxt_w, nxt_p2;
	logic [MUX_W-1:0]  tgt;

	always_comb begin
		ch_w   = SKIP_W'(idx_q);
		nxt_w  = (ch_w == SKIP_W'(NUM_CHANNELS - 1)) ? '0 : ch_w + SKIP_W'(1);
		nxt_p2 = nxt_w + SKIP_W'(2);
		tgt    = nxt_p2[MUX_W+1:2];

		idx_d   = idx_q;
		a_cur_d = a_cur_q;
		a_tgt_d = a_tgt_q;
		b_cur_d = b_cur_q;
		b_tgt_d = b_tgt_q;
		res     = '0;
		res.conv = (mode == mascd_pkg::MODE_CONV);

		if (mode == mascd_pkg::MODE_CONV) begin
			res.ch = mascd_pkg::CH_W'(idx_q);
			if (nxt_w < skip_from_channel) begin
				idx_d = IDX_W'(nxt_w);
				// ping-pong: odd pair of channels retargets A, even pair B
				if (nxt_w[1]) begin
					a_tgt_d = tgt;
				end else begin
					b_tgt_d = tgt;
				end
				res.adc_select = nxt_w[1:0];
			end else begin
				idx_d   = '0;
				a_cur_d = '0;
				a_tgt_d = '0;
				b_cur_d = '0;
				b_tgt_d = '0;
				res.mux_reset  = 1'b1;
				res.adc_select = mascd_pkg::SEL_AFTER_RESET;
			end
		end else begin
			if (a_cur_q != a_tgt_q) begin
				res.mux_a_clk = 1'b1;
				a_cur_d = a_tgt_q;
			end
			if (b_cur_q != b_tgt_q) begin
				res.mux_b_clk = 1'b1;
				b_cur_d = b_tgt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			a_cur_q <= '0;
			a_tgt_q <= '0;
			b_cur_q <= '0;
			b_tgt_q <= '0;
		end else if (accept) begin
			idx_q   <= idx_d;
			a_cur_q <= a_cur_d;
			a_tgt_q <= a_tgt_d;
			b_cur_q <= b_cur_d;
			b_tgt_q <= b_tgt_d;
		end
	end

	assign rd_addr = idx_q;

endmodule

// ===== sv/muxed_adc_scan_change_detect.sv =====
// Scans up to NUM_CHANNELS analog inputs through two external counter muxes.
// A conversion word (s_tuser low) stores its sample for the current channel,
// flags a change against the previous reading, steps the channel and yields
// the next converter select and mux reset; a tick word (s_tuser high) yields
// the mux clock pulses. One result word per input word. Throughput is one
// word per clock while m_tready is high: the reading store is a
// single-port-write memory with a registered read, read when a word is taken
// and written back the cycle its result leaves for the output register, with
// a bypass when both hit the same entry. A word passes through stage 1 and
// the output register. The store reads as zero after reset through per-entry
// valid flags, so no clearing pass is needed.
module muxed_adc_scan_change_detect #(
	parameter int NUM_CHANNELS = mascd_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mascd_pkg::IN_DATA_W-1:0]      s_tdata,   // sample[9:0]
	input  logic                                 s_tuser,   // mode
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// sampled_channel[4:0], reading[14:5], changed[15], adc_select[17:16],
	// mux_reset_pulse[18], mux_a_clock_pulse[19], mux_b_clock_pulse[20]
	output logic [mascd_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mascd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mascd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IDX_W    = $clog2(NUM_CHANNELS);
	localparam int SAMPLE_W = mascd_pkg::SAMPLE_W;

	logic [SAMPLE_W-1:0]           thr_q;
	logic [mascd_pkg::MASK_W-1:0]  mask_q;
	logic [mascd_pkg::SKIP_W-1:0]  skip_q;

	logic                 accept, advance, move;
	logic [IDX_W-1:0]     rd_addr;
	logic [SAMPLE_W-1:0]  old_rd;
	logic [SAMPLE_W-1:0]  diff;
	logic                 changed;
	mascd_pkg::scan_res_t res;

	logic                 valid_s1;
	mascd_pkg::scan_res_t res_s1;
	logic [SAMPLE_W-1:0]  sample_s1;

	logic                        out_valid_q;
	logic [mascd_pkg::OUT_W-1:0] out_q;
	logic [mascd_pkg::OUT_W-1:0] out_d;

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= mascd_pkg::THRESHOLD_RST;
			mask_q <= '0;
			skip_q <= mascd_pkg::SKIP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				mascd_pkg::CFG_THRESHOLD: thr_q  <= cfg_data[SAMPLE_W-1:0];
				mascd_pkg::CFG_ENABLE:    mask_q <= cfg_data[mascd_pkg::MASK_W-1:0];
				mascd_pkg::CFG_SKIP:      skip_q <= cfg_data[mascd_pkg::SKIP_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: output register frees stage 1, stage 1 frees the input
	assign advance  = !out_valid_q || m_tready;
	assign move     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	mascd_scan #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_scan (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.mode              (s_tuser),
		.skip_from_channel (skip_q),
		.rd_addr           (rd_addr),
		.res               (res)
	);

	mascd_store #(
		.DEPTH  (NUM_CHANNELS),
		.DATA_W (SAMPLE_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (old_rd),
		.wr_en   (move && res_s1.conv),
		.wr_addr (res_s1.ch[IDX_W-1:0]),
		.wr_data (sample_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1    <= res;
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		diff    = (old_rd > sample_s1) ? old_rd - sample_s1 : sample_s1 - old_rd;
		changed = res_s1.conv && mask_q[res_s1.ch] && (diff > thr_q);
		out_d   = {res_s1.mux_b_clk, res_s1.mux_a_clk, res_s1.mux_reset,
			res_s1.adc_select, changed,
			res_s1.conv ? sample_s1 : SAMPLE_W'(0), res_s1.ch};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q <= out_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = mascd_pkg::OUT_DATA_W'(out_q);

endmodule
